/* rtl/ppmd_pkg.sv */
package ppmd_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_MAGIC    = 2'd0;
    localparam logic [1:0] ERR_HEADER   = 2'd1;
    localparam logic [1:0] ERR_MISMATCH = 2'd2;

    localparam logic [7:0]  CH_P     = 8'h50;
    localparam logic [7:0]  CH_SIX   = 8'h36;
    localparam logic [7:0]  CH_HASH  = 8'h23;
    localparam logic [7:0]  CH_LF    = 8'd10;
    localparam logic [7:0]  CH_SEP_LO = 8'd9;
    localparam logic [7:0]  CH_SEP_HI = 8'd13;
    localparam logic [7:0]  CH_ZERO  = 8'd48;
    localparam logic [7:0]  CH_NINE  = 8'd57;
    localparam logic [16:0] ACC_SAT  = 17'd65536;

    // Dividend is sample*255, at most 24 bits; divisor is maxval, 16 bits.
    localparam int QUOT_BITS = 8;
    localparam int DIVD_BITS = 24;

    typedef struct packed {
        logic        start;
        logic [15:0] sample;
        logic [15:0] maxval;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] value;
    } t_div_rsp;

endpackage

/* rtl/ppmd_scale_div.sv */
// Restoring divider that produces sample*255/maxval one quotient bit per
// cycle. Any quotient above 255, or a zero maxval, saturates, detected up
// front by comparing the dividend's top part with the divisor.
module ppmd_scale_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppmd_pkg::t_div_req i_req,
    output ppmd_pkg::t_div_rsp o_rsp
);
    import ppmd_pkg::*;

    logic [23:0] r_divd;
    logic [15:0] r_rem;
    logic [15:0] r_dvs;
    logic [7:0]  r_quot;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [23:0] prod;
    logic [16:0] trial;
    logic [17:0] diff;

    // sample*255 = (sample<<8) - sample.
    assign prod  = {i_req.sample, 8'd0} - {8'd0, i_req.sample};
    assign trial = {r_rem, r_divd[23]};
    assign diff  = {1'b0, trial} - {2'd0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_dvs  <= i_req.maxval;
                r_quot <= 8'd0;
                // If prod>>8 >= maxval, the quotient is at least 256.
                if ({1'b0, prod[23:8]} >= {1'b0, i_req.maxval} || i_req.maxval == 16'd0) begin
                    r_quot <= 8'hFF;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= prod[23:8];
                    r_divd <= {prod[7:0], 16'd0};
                    r_cnt  <= 4'd8;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_divd <= {r_divd[22:0], 1'b0};
                // The remainder stays below the divisor, so 16 bits hold it.
                if (!diff[17]) begin
                    r_rem  <= diff[15:0];
                    r_quot <= {r_quot[6:0], 1'b1};
                end else begin
                    r_rem  <= trial[15:0];
                    r_quot <= {r_quot[6:0], 1'b0};
                end
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_quot;

endmodule

/* rtl/ppm_p6_stream_decoder_unit.sv */
// Streaming P6 image decoder. One file byte enters per input transaction
// (i_data_byte, with i_end_of_stream on the final byte). Each byte yields
// at most one result transaction: a header report, a pixel, or an error.
// A raster byte that completes a sample passes through one shared restoring
// divider, which forms sample*255/maxval one quotient bit per cycle; a
// saturating sample skips the loop. The input is not ready while a byte
// is in work. A byte accepted while a result waits in the output register
// is held until that register frees, so a stalled receiver stalls input
// after one result and one further byte. Reset, and the end of every
// stream, return the parser to waiting for the magic 'P' with all counters
// cleared. After an error further bytes are dropped without result until
// the end-of-stream byte. Image dimensions above 2^DIM_BITS-1, capped at
// 65535, are rejected as an invalid header.
module ppm_p6_stream_decoder_unit #(
    parameter int DIM_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic       o_wide_samples,
    output logic [1:0] o_error_code,
    output logic       o_last_pixel
);
    import ppmd_pkg::*;

    localparam logic [16:0] DIM_LIMIT = (DIM_BITS >= 16) ? 17'd65535 :
                                        17'((1 << DIM_BITS) - 1);
    // Stored dimensions never exceed 16 bits.
    localparam int DIM_W    = (DIM_BITS >= 16) ? 16 : DIM_BITS;
    localparam int PIX_BITS = 2 * DIM_W;

    typedef enum logic [3:0] {
        PH_P, PH_SIX, PH_SEP, PH_SKIP_W, PH_NUM_W, PH_SKIP_H, PH_NUM_H,
        PH_SKIP_M, PH_NUM_M, PH_RASTER, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_OUT} t_state;

    t_state      r_state;
    t_phase      r_phase;
    logic        r_in_comment;
    logic [16:0] r_acc;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [15:0] r_maxval;
    logic [2:0]  r_bip;
    logic [7:0]  r_hi;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [PIX_BITS-1:0] r_left;
    logic        r_err;
    logic [7:0]  r_byte;
    logic        r_eos;
    t_phase      r_entry;

    logic        r_ovalid;
    logic [1:0]  r_kind;
    logic [7:0]  r_ored, r_ogreen, r_oblue;
    logic [15:0] r_ow, r_oh;
    logic        r_owide, r_olast;
    logic [1:0]  r_ocode;

    t_div_req div_req;
    t_div_rsp div_rsp;

    ppmd_scale_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    logic is_dig, wide;
    logic [3:0]  dig;
    logic [20:0] acc_mul;
    logic [16:0] acc_next;
    logic [2:0]  comp;

    assign is_dig   = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
    assign dig      = 4'(r_byte - CH_ZERO);
    assign acc_mul  = {r_acc, 3'd0} + {2'd0, r_acc, 1'd0} + {17'd0, dig};
    assign acc_next = (acc_mul > {4'd0, ACC_SAT}) ? ACC_SAT : acc_mul[16:0];
    assign wide     = r_maxval > 16'd255;
    assign comp     = wide ? {1'b0, r_bip[2:1]} : r_bip;

    // A raster byte needs the divider unless it is the high byte of a wide sample.
    logic need_div;
    assign need_div = (r_phase == PH_RASTER) && !r_err && !(wide && !r_bip[0]);

    assign div_req.start  = (r_state == ST_EXEC) && need_div;
    assign div_req.sample = wide ? {r_hi, r_byte} : {8'd0, r_byte};
    assign div_req.maxval = r_maxval;

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        logic       emit;
        logic [1:0] ek;
        logic [1:0] ecode;
        logic       errnow;
        t_phase     ph;
        logic [16:0] fin;
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_P;
            r_in_comment <= 1'b0;
            r_acc        <= 17'd0;
            r_width      <= 16'd0;
            r_height     <= 16'd0;
            r_maxval     <= 16'd0;
            r_bip        <= 3'd0;
            r_hi         <= 8'd0;
            r_red        <= 8'd0;
            r_green      <= 8'd0;
            r_left       <= '0;
            r_err        <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            emit   = 1'b0;
            ek     = KIND_ERROR;
            ecode  = ERR_MAGIC;
            errnow = 1'b0;
            ph     = r_phase;
            fin    = (r_acc > DIM_LIMIT) ? 17'd0 : r_acc;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_byte  <= i_data_byte;
                        r_eos   <= i_end_of_stream;
                        r_entry <= r_phase;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC, ST_DIV, ST_OUT: begin
                    if (r_state == ST_EXEC && need_div) begin
                        r_state <= ST_DIV;
                    end else if (!r_ovalid || i_ready) begin
                        // Finish the transaction; the output register is free here.
                        if (r_state == ST_DIV && !div_rsp.done) begin
                            r_state <= ST_DIV;
                        end else if (r_err) begin
                            r_state <= ST_IDLE;
                            if (r_eos) begin
                                r_err <= 1'b0; r_phase <= PH_P; r_in_comment <= 1'b0;
                                r_acc <= 17'd0; r_width <= 16'd0; r_height <= 16'd0;
                                r_maxval <= 16'd0; r_bip <= 3'd0; r_hi <= 8'd0;
                                r_red <= 8'd0; r_green <= 8'd0; r_left <= '0;
                            end
                        end else begin
                            r_state <= ST_IDLE;
                            case (r_phase)
                                PH_P: begin
                                    if (r_byte == CH_P) ph = PH_SIX;
                                    else begin errnow = 1'b1; ecode = ERR_MAGIC; end
                                end
                                PH_SIX: begin
                                    if (r_byte == CH_SIX) ph = PH_SEP;
                                    else begin errnow = 1'b1; ecode = ERR_MAGIC; end
                                end
                                PH_SEP: begin
                                    if (r_byte >= CH_SEP_LO && r_byte <= CH_SEP_HI) begin
                                        ph = PH_SKIP_W; r_in_comment <= 1'b0;
                                    end else begin errnow = 1'b1; ecode = ERR_MAGIC; end
                                end
                                PH_SKIP_W, PH_SKIP_H, PH_SKIP_M, PH_NUM_W, PH_NUM_H: begin
                                    if ((r_phase == PH_NUM_W || r_phase == PH_NUM_H) && is_dig) begin
                                        r_acc <= acc_next;
                                    end else begin
                                        logic   cmt;
                                        t_phase np;
                                        cmt = r_in_comment;
                                        np  = t_phase'(r_phase + 4'd1);
                                        if (r_phase == PH_NUM_W || r_phase == PH_NUM_H) begin
                                            if (r_phase == PH_NUM_W) r_width <= fin[15:0];
                                            else r_height <= fin[15:0];
                                            cmt = 1'b0;
                                            ph  = r_phase;
                                            np  = t_phase'(r_phase + 4'd2);
                                        end
                                        r_in_comment <= cmt;
                                        if (cmt) begin
                                            if (r_byte == CH_LF) r_in_comment <= 1'b0;
                                        end else if (is_dig) begin
                                            r_acc <= {13'd0, dig};
                                            ph = np;
                                        end else if (r_byte == CH_HASH) begin
                                            r_in_comment <= 1'b1;
                                        end
                                        if (r_phase == PH_NUM_W || r_phase == PH_NUM_H) begin
                                            if (!(!cmt && is_dig)) ph = t_phase'(r_phase + 4'd1);
                                        end
                                    end
                                end
                                PH_NUM_M: begin
                                    if (is_dig) r_acc <= acc_next;
                                    else if (r_width != 16'd0 && r_height != 16'd0 &&
                                             r_acc != 17'd0 && r_acc < ACC_SAT) begin
                                        r_maxval <= r_acc[15:0];
                                        r_left   <= PIX_BITS'(r_width[DIM_W-1:0]) *
                                                    PIX_BITS'(r_height[DIM_W-1:0]);
                                        r_bip    <= 3'd0;
                                        ph       = PH_RASTER;
                                        emit     = 1'b1;
                                        ek       = KIND_HEADER;
                                        r_ow     <= r_width;
                                        r_oh     <= r_height;
                                        r_owide  <= r_acc > 17'd255;
                                    end else begin errnow = 1'b1; ecode = ERR_HEADER; end
                                end
                                PH_RASTER: begin
                                    if (!need_div) begin
                                        r_hi  <= r_byte;
                                        r_bip <= r_bip + 3'd1;
                                    end else if (comp == 3'd0) begin
                                        r_red <= div_rsp.value; r_bip <= r_bip + 3'd1;
                                    end else if (comp == 3'd1) begin
                                        r_green <= div_rsp.value; r_bip <= r_bip + 3'd1;
                                    end else begin
                                        emit = 1'b1; ek = KIND_PIXEL;
                                        r_ored <= r_red; r_ogreen <= r_green;
                                        r_oblue <= div_rsp.value;
                                        r_bip <= 3'd0;
                                        r_olast <= (r_left <= PIX_BITS'(1));
                                        if (r_left != '0) r_left <= r_left - PIX_BITS'(1);
                                        if (r_left <= PIX_BITS'(1)) ph = PH_DONE;
                                    end
                                end
                                default: ;
                            endcase
                            if (r_eos && !errnow) begin
                                if (r_entry == PH_DONE || ph == PH_RASTER) begin
                                    errnow = 1'b1; ecode = ERR_MISMATCH;
                                end else if (ph == PH_DONE) begin
                                end else if (ph == PH_P || ph == PH_SIX || ph == PH_SEP) begin
                                    errnow = 1'b1; ecode = ERR_MAGIC;
                                end else begin
                                    errnow = 1'b1; ecode = ERR_HEADER;
                                end
                            end
                            if (errnow) begin
                                emit = 1'b1; ek = KIND_ERROR;
                                r_ocode <= ecode;
                            end
                            if (emit) begin
                                r_ovalid <= 1'b1;
                                r_kind   <= ek;
                            end
                            r_phase <= ph;
                            r_err   <= errnow && !r_eos;
                            if (r_eos) begin
                                r_phase <= PH_P; r_in_comment <= 1'b0;
                                r_acc <= 17'd0; r_width <= 16'd0; r_height <= 16'd0;
                                r_maxval <= 16'd0; r_bip <= 3'd0; r_hi <= 8'd0;
                                r_red <= 8'd0; r_green <= 8'd0; r_left <= '0;
                            end
                        end
                    end else if (r_state == ST_DIV && div_rsp.done) begin
                        // Hold the quotient until the output register drains.
                        r_state <= ST_OUT;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_kind         = r_kind;
    assign o_red_out      = (r_kind == KIND_PIXEL) ? r_ored : 8'd0;
    assign o_green_out    = (r_kind == KIND_PIXEL) ? r_ogreen : 8'd0;
    assign o_blue_out     = (r_kind == KIND_PIXEL) ? r_oblue : 8'd0;
    assign o_last_pixel   = (r_kind == KIND_PIXEL) ? r_olast : 1'b0;
    assign o_image_width  = (r_kind == KIND_HEADER) ? r_ow : 16'd0;
    assign o_image_height = (r_kind == KIND_HEADER) ? r_oh : 16'd0;
    assign o_wide_samples = (r_kind == KIND_HEADER) ? r_owide : 1'b0;
    assign o_error_code   = (r_kind == KIND_ERROR) ? r_ocode : 2'd0;

endmodule

/* rtl/ppmd_checker.sv */
module ppmd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_blue_out
);
    import ppmd_pkg::*;

    // The decoder is not ready in the cycle after each accepted input transaction.
    a_ready_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_kind) && $stable(o_blue_out)))
        else $error("result changed while stalled");

    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind == KIND_HEADER || o_kind == KIND_PIXEL || o_kind == KIND_ERROR))
        else $error("bad result kind");

    a_out_needs_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && $past(o_ready) && o_ready) |=> !o_valid)
        else $error("result without an input transaction");

endmodule

bind ppm_p6_stream_decoder_unit ppmd_checker u_ppmd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_kind    (o_kind),
    .o_blue_out(o_blue_out)
);

/* sim/tb_ppm_p6_stream_decoder_unit.sv */
`timescale 1ns / 100ps

module tb_ppm_p6_stream_decoder_unit;
    import ppmd_pkg::*;

    localparam int DIM_BITS = 16;
    localparam logic [15:0] DIM_LIMIT = 16'd65535;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum logic [3:0] {
        ST_P, ST_SIX, ST_SEP, ST_SKIP_W, ST_NUM_W, ST_SKIP_H, ST_NUM_H,
        ST_SKIP_M, ST_NUM_M, ST_RASTER, ST_DONE
    } t_parse_state;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_file_byte;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] width;
        logic [15:0] height;
        logic        wide;
        logic [1:0]  err;
        logic        last;
    } t_decode_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [7:0] i_data_byte = 8'd0;
    logic i_end_of_stream = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_red_out, o_green_out, o_blue_out;
    logic [15:0] o_image_width, o_image_height;
    logic o_wide_samples;
    logic [1:0] o_error_code;
    logic o_last_pixel;

    ppm_p6_stream_decoder_unit #(.DIM_BITS(DIM_BITS)) u_top (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state.
    t_parse_state pst;
    logic         p_comment;
    logic [16:0]  p_acc;
    logic [15:0]  p_width, p_height, p_maxval;
    logic [2:0]   p_byte_idx;
    logic [7:0]   p_hi, p_red, p_green;
    logic [31:0]  p_left;
    logic         p_err;

    t_file_byte     file_bytes[$];
    t_decode_result expected_results[$];
    int  mismatches = 0;
    bit  stim_done = 0;
    bit  hold_for_drain = 0;
    int  idle_cycles = 0;

    task automatic decoder_clear();
        pst = ST_P; p_comment = 0; p_acc = 0; p_width = 0; p_height = 0;
        p_maxval = 0; p_byte_idx = 0; p_hi = 0; p_red = 0; p_green = 0;
        p_left = 0; p_err = 0;
    endtask

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    task automatic skip_char(logic [7:0] b, t_parse_state num_st);
        if (p_comment) begin
            if (b == CH_LF) p_comment = 0;
        end else if (is_digit(b)) begin
            p_acc = 17'(b - CH_ZERO);
            pst = num_st;
        end else if (b == CH_HASH) begin
            p_comment = 1;
        end
    endtask

    function automatic logic [7:0] rescale(logic [15:0] sample);
        logic [31:0] q;
        if (p_maxval == 0) return 8'd255;
        q = (32'(sample) * 255) / p_maxval;
        return q > 255 ? 8'd255 : q[7:0];
    endfunction

    // Sets got and fills r when the byte yields a result.
    task automatic decode_byte(t_file_byte fb, output bit got, output t_decode_result r);
        logic [7:0] b;
        t_parse_state entry;
        bit err;
        bit wide;
        logic [15:0] sample;
        logic [2:0] comp;
        logic [7:0] val;
        logic [31:0] acc_next;
        b = fb.data; entry = pst; err = 0; got = 0; r = '0;
        if (p_err) begin
            if (fb.eos) decoder_clear();
            return;
        end
        case (pst)
            ST_P, ST_SIX, ST_SEP: begin
                if ((pst == ST_P && b == CH_P) || (pst == ST_SIX && b == CH_SIX)) begin
                    pst = t_parse_state'(pst + 1);
                end else if (pst == ST_SEP && b >= CH_SEP_LO && b <= CH_SEP_HI) begin
                    pst = ST_SKIP_W; p_comment = 0;
                end else begin
                    r.kind = KIND_ERROR; r.err = ERR_MAGIC; got = 1; err = 1; p_err = 1;
                end
            end
            ST_SKIP_W: skip_char(b, ST_NUM_W);
            ST_SKIP_H: skip_char(b, ST_NUM_H);
            ST_SKIP_M: skip_char(b, ST_NUM_M);
            ST_NUM_W, ST_NUM_H, ST_NUM_M: begin
                if (is_digit(b)) begin
                    acc_next = 32'(p_acc) * 10 + (b - CH_ZERO);
                    p_acc = acc_next > ACC_SAT ? ACC_SAT : acc_next[16:0];
                end else if (pst == ST_NUM_W || pst == ST_NUM_H) begin
                    if (pst == ST_NUM_W) begin
                        p_width = p_acc > DIM_LIMIT ? 16'd0 : p_acc[15:0];
                        pst = ST_SKIP_H; p_comment = 0; skip_char(b, ST_NUM_H);
                    end else begin
                        p_height = p_acc > DIM_LIMIT ? 16'd0 : p_acc[15:0];
                        pst = ST_SKIP_M; p_comment = 0; skip_char(b, ST_NUM_M);
                    end
                end else if (p_width != 0 && p_height != 0 && p_acc != 0 && p_acc < ACC_SAT) begin
                    p_maxval = p_acc[15:0];
                    p_left = 32'(p_width) * 32'(p_height);
                    p_byte_idx = 0; pst = ST_RASTER;
                    r.kind = KIND_HEADER; r.width = p_width; r.height = p_height;
                    r.wide = p_maxval > 255; got = 1;
                end else begin
                    r.kind = KIND_ERROR; r.err = ERR_HEADER; got = 1; err = 1; p_err = 1;
                end
            end
            ST_RASTER: begin
                wide = p_maxval > 255;
                if (wide && !p_byte_idx[0]) begin
                    p_hi = b; p_byte_idx = p_byte_idx + 1;
                end else begin
                    sample = wide ? {p_hi, b} : {8'd0, b};
                    comp = wide ? (p_byte_idx >> 1) : p_byte_idx;
                    val = rescale(sample);
                    if (comp == 0) begin
                        p_red = val; p_byte_idx = p_byte_idx + 1;
                    end else if (comp == 1) begin
                        p_green = val; p_byte_idx = p_byte_idx + 1;
                    end else begin
                        r.kind = KIND_PIXEL; r.red = p_red; r.green = p_green; r.blue = val;
                        got = 1; p_byte_idx = 0;
                        if (p_left > 0) p_left--;
                        if (p_left == 0) begin
                            r.last = 1; pst = ST_DONE;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (fb.eos) begin
            if (!err) begin
                if (entry == ST_DONE || pst == ST_RASTER) begin
                    r = '0; r.kind = KIND_ERROR; r.err = ERR_MISMATCH; got = 1;
                end else if (pst != ST_DONE) begin
                    r = '0; r.kind = KIND_ERROR; got = 1;
                    r.err = pst <= ST_SEP ? ERR_MAGIC : ERR_HEADER;
                end
            end
            decoder_clear();
        end
    endtask

    // Stimulus construction helpers.
    task automatic push(logic [7:0] b, bit eos = 0);
        file_bytes.push_back('{data: b, eos: eos});
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push(s[i]);
    endtask

    task automatic push_blank();
        // Random whitespace or junk, sometimes with a comment.
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) push(8'($urandom_range(9, 13)));
        else if (k < 8) push(8'h20);
        else if (k == 8) begin
            push(CH_HASH);
            repeat ($urandom_range(0, 4)) push(8'($urandom_range(0, 255)) & 8'hF7);
            push(CH_LF);
        end else push(8'($urandom_range(0, 47)));
    endtask

    // Builds a file; tail_adj shifts the raster length, eos always on the last byte.
    task automatic push_image(int w, int h, int maxv, int tail_adj);
        int nbytes;
        push(CH_P); push(CH_SIX); push(8'($urandom_range(9, 13)));
        if ($urandom_range(0, 2) == 0) push_blank();
        push_text($sformatf("%0d", w)); push_blank();
        push_text($sformatf("%0d", h)); push_blank();
        push_text($sformatf("%0d", maxv));
        nbytes = w * h * 3 * (maxv > 255 ? 2 : 1) + tail_adj;
        if (nbytes <= 0) begin
            push(8'h0A, 1);
            return;
        end
        push(8'h0A);
        for (int i = 0; i < nbytes; i++) begin
            logic [7:0] b;
            case ($urandom_range(0, 5))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            push(b, i == nbytes - 1);
        end
    endtask

    function automatic int rand_maxval();
        case ($urandom_range(0, 5))
            0: return 255;
            1: return $urandom_range(1, 255);
            2: return 65535;
            3: return $urandom_range(256, 65535);
            4: return $urandom_range(1, 3);
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    initial begin
        decoder_clear();
        // Directed files.
        push_image(1, 1, 255, 0);
        push_image(2, 1, 65535, 0);
        push_image(1, 2, 7, 0);
        push_text("P6\n#c\n1 1 300 ");
        for (int i = 0; i < 6; i++) push(8'hFF, i == 5);
        push_text("Q"); push(8'h00, 1);
        push_text("P5"); push(8'h00, 1);
        push_text("P6 "); push(8'h00, 1);
        push_text("P6\n0 1 255\n"); push(8'h00, 1);
        push_text("P6\n1 1 65536\n"); push(8'h00, 1);
        push_text("P6\n99999 1 255\n"); push(8'h00, 1);
        push_text("P6\n1 1 0\n"); push(8'h00, 1);
        push_text("P6\n4 4"); push(8'h20, 1);
        push(CH_P, 1);
        push_image(1, 1, 255, 3);
        push_image(2, 1, 255, -2);
        push_image(1, 1, 255, -3);
        while (file_bytes.size() < 720) begin
            int kind;
            kind = $urandom_range(0, 19);
            if (kind < 15) begin
                push_image($urandom_range(1, 4), $urandom_range(1, 3), rand_maxval(),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) - 2 : 0);
            end else if (kind < 18) begin
                // Truncated or broken header.
                push_text("P6\n");
                repeat ($urandom_range(0, 6)) push(8'($urandom_range(0, 255)));
                push(8'($urandom_range(0, 255)), 1);
            end else begin
                repeat ($urandom_range(1, 6)) push(8'($urandom_range(0, 255)));
                push(8'($urandom_range(0, 255)), 1);
            end
        end
        // Release reset once the whole queue is built.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Acceptance seen at the last rising edge, for the driver.
    bit o_ready_seen = 0;

    // Driver: bursts with random gaps, and a full drain pause midway.
    int burst_left = 0;
    int gap_left = 0;
    int sent = 0;
    bit drained_once = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || (i_valid && o_ready_seen)) begin
                if (sent == 300 && !drained_once) begin
                    i_valid <= 1'b0;
                    if (expected_results.size() == 0) drained_once = 1;
                end else if (file_bytes.size() == 0) begin
                    i_valid <= 1'b0;
                    stim_done = 1;
                end else if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    {i_data_byte, i_end_of_stream} <= file_bytes.pop_front();
                    sent++;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            i_ready <= ($urandom_range(0, 3) != 0) || (sent % 200 < 40);
        end
    end

    always @(posedge i_clk) begin
        t_decode_result r, e;
        bit got;
        o_ready_seen <= i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                decode_byte('{data: i_data_byte, eos: i_end_of_stream}, got, r);
                if (got) expected_results.push_back(r);
            end
            if (o_valid && i_ready) begin
                r = '{o_kind, o_red_out, o_green_out, o_blue_out, o_image_width,
                      o_image_height, o_wide_samples, o_error_code, o_last_pixel};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %p", r);
                end else begin
                    e = expected_results.pop_front();
                    if (r !== e) begin
                        mismatches++;
                        if (mismatches <= 10) $display("Mismatch: expected %p, got %p", e, r);
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (i_rst_n);
        fork
            begin
                wait (stim_done && !i_valid && expected_results.size() == 0);
                repeat (50) @(posedge i_clk);
            end
            wait (idle_cycles >= WATCHDOG_LIMIT);
        join_any
        if (idle_cycles < WATCHDOG_LIMIT && mismatches == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
